/* rtl/line_rasterizer_all_octants_assert.svh */
// ----------------------------------------------------------------------------
// Line rasterizer assertion macros
// Shared helpers for the concurrent checks of the line rasterizer.
// ----------------------------------------------------------------------------
`ifndef LINE_RASTERIZER_ALL_OCTANTS_ASSERT_SVH
`define LINE_RASTERIZER_ALL_OCTANTS_ASSERT_SVH

// The consequent must hold in the cycle after the antecedent.
`define LRA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define LRA_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

/* rtl/lra_pkg.sv */
// ----------------------------------------------------------------------------
// Line rasterizer package
// Widths, codes and shared types of the line rasterizer.
// ----------------------------------------------------------------------------
`default_nettype none

package lra_pkg;

    localparam int COORD_BITS = 12;
    localparam int COLOR_BITS = 8;
    localparam int ERR_BITS   = COORD_BITS + 3;

    typedef logic [COORD_BITS-1:0]      coord_t;
    typedef logic [COLOR_BITS-1:0]      color_t;
    typedef logic signed [ERR_BITS-1:0] err_t;

    typedef enum logic {
        ACT_LOAD = 1'b0,
        ACT_STEP = 1'b1
    } action_t;

    // Line geometry after ordering, mirroring and axis swap.
    typedef struct packed {
        coord_t origin_x;
        coord_t origin_y;
        coord_t major_length;
        coord_t minor_length;
        logic   steep;
        logic   mirror;
    } line_setup_t;

    // Position of the walk along the line.
    typedef struct packed {
        coord_t major_offset;
        coord_t minor_offset;
        err_t   error_term;
    } walk_t;

endpackage

`default_nettype wire

/* rtl/line_rasterizer_all_octants.sv */
// A step beat with an active line shows its pixel in the cycle after acceptance.
// One beat per cycle unless the output stalls; a step is one add, compare and mirror.
// A load beat gives no pixel and takes effect for the very next step beat.
// Reset (rst_n low, asynchronous) clears the line state and empties the output.
// ----------------------------------------------------------------------------
// Bresenham line rasterizer, all octants
// Loads a line from two endpoints and a color, then emits one pixel per step
// beat, ending with the far endpoint flagged as the last pixel.
// ----------------------------------------------------------------------------
`default_nettype none

`include "line_rasterizer_all_octants_assert.svh"

module line_rasterizer_all_octants (
    input  wire                   clk,
    input  wire                   rst_n,

    // Command channel.
    input  wire                   item_valid,
    output logic                  item_ready,
    input  wire                   action,
    input  wire lra_pkg::coord_t  start_x,
    input  wire lra_pkg::coord_t  start_y,
    input  wire lra_pkg::coord_t  end_x,
    input  wire lra_pkg::coord_t  end_y,
    input  wire lra_pkg::color_t  red_in,
    input  wire lra_pkg::color_t  green_in,
    input  wire lra_pkg::color_t  blue_in,

    // Pixel channel.
    output logic                  pixel_valid,
    input  wire                   pixel_ready,
    output lra_pkg::coord_t       pixel_x,
    output lra_pkg::coord_t       pixel_y,
    output lra_pkg::color_t       red_out,
    output lra_pkg::color_t       green_out,
    output lra_pkg::color_t       blue_out,
    output logic                  last_pixel
);
    import lra_pkg::*;

    // Line state. The geometry is held as one struct so that the step logic
    // sees it as a unit; the walk position moves on every emitted pixel.
    logic        line_active_reg;
    logic        line_active_next;
    line_setup_t line_cfg_reg;
    line_setup_t line_cfg_next;
    walk_t       walk_reg;
    walk_t       walk_next;
    color_t      red_reg;
    color_t      green_reg;
    color_t      blue_reg;
    color_t      red_next;
    color_t      green_next;
    color_t      blue_next;

    // Output register.
    logic        pixel_valid_reg;
    logic        pixel_valid_next;
    coord_t      pixel_x_reg;
    coord_t      pixel_y_reg;
    color_t      red_out_reg;
    color_t      green_out_reg;
    color_t      blue_out_reg;
    logic        last_pixel_reg;

    line_setup_t load_setup;
    coord_t      step_x;
    coord_t      step_y;
    logic        step_last;
    walk_t       step_walk;

    logic        item_fire;
    logic        is_step;
    logic        do_load;
    logic        do_emit;

    // A new beat is taken whenever the output register is empty or is being
    // drained in the same cycle, so the block runs at one beat per clock.
    assign item_ready = !pixel_valid_reg || pixel_ready;
    assign item_fire  = item_valid && item_ready;
    assign is_step    = (action == ACT_STEP);
    assign do_load    = item_fire && !is_step;
    // A step beat while no line is active is consumed without a pixel.
    assign do_emit    = item_fire && is_step && line_active_reg;

    lra_setup u_setup (
        .start_x (start_x),
        .start_y (start_y),
        .end_x   (end_x),
        .end_y   (end_y),
        .setup   (load_setup)
    );

    lra_step u_step (
        .line_cfg  (line_cfg_reg),
        .walk      (walk_reg),
        .pixel_x   (step_x),
        .pixel_y   (step_y),
        .last      (step_last),
        .walk_next (step_walk)
    );

    // Next line state.
    always_comb
    begin
        line_active_next = line_active_reg;
        line_cfg_next    = line_cfg_reg;
        walk_next        = walk_reg;
        red_next         = red_reg;
        green_next       = green_reg;
        blue_next        = blue_reg;

        if (do_load)
        begin
            // The error term starts at minus the major length.
            line_active_next       = 1'b1;
            line_cfg_next          = load_setup;
            walk_next.major_offset = '0;
            walk_next.minor_offset = '0;
            walk_next.error_term   = -err_t'({3'b000, load_setup.major_length});
            red_next               = red_in;
            green_next             = green_in;
            blue_next              = blue_in;
        end
        else if (do_emit)
        begin
            // The final endpoint ends the line; the walk does not move past it.
            if (step_last)
            begin
                line_active_next = 1'b0;
            end
            else
            begin
                walk_next = step_walk;
            end
        end
    end

    // The output holds its beat until the consumer takes it.
    always_comb
    begin
        if (do_emit)
        begin
            pixel_valid_next = 1'b1;
        end
        else if (pixel_ready)
        begin
            pixel_valid_next = 1'b0;
        end
        else
        begin
            pixel_valid_next = pixel_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_active_reg <= 1'b0;
            line_cfg_reg    <= '0;
            walk_reg        <= '0;
            red_reg         <= '0;
            green_reg       <= '0;
            blue_reg        <= '0;
            pixel_valid_reg <= 1'b0;
        end
        else
        begin
            line_active_reg <= line_active_next;
            line_cfg_reg    <= line_cfg_next;
            walk_reg        <= walk_next;
            red_reg         <= red_next;
            green_reg       <= green_next;
            blue_reg        <= blue_next;
            pixel_valid_reg <= pixel_valid_next;
        end
    end

    // Pixel payload is loaded only with a new beat, so it needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_emit)
        begin
            pixel_x_reg    <= step_x;
            pixel_y_reg    <= step_y;
            red_out_reg    <= red_reg;
            green_out_reg  <= green_reg;
            blue_out_reg   <= blue_reg;
            last_pixel_reg <= step_last;
        end
    end

    assign pixel_valid = pixel_valid_reg;
    assign pixel_x     = pixel_x_reg;
    assign pixel_y     = pixel_y_reg;
    assign red_out     = red_out_reg;
    assign green_out   = green_out_reg;
    assign blue_out    = blue_out_reg;
    assign last_pixel  = last_pixel_reg;

    // A step on an idle block must leave the output empty.
    `LRA_ASSERT_NEXT(a_idle_step_silent, item_fire && is_step && !line_active_reg, !pixel_valid_reg, "step while idle produced a pixel")
    // A step on an active line always produces a pixel.
    `LRA_ASSERT_NEXT(a_step_emits, do_emit, pixel_valid_reg, "active step produced no pixel")
    // The final endpoint closes the line.
    `LRA_ASSERT_NEXT(a_last_ends_line, do_emit && step_last && !(item_fire && !is_step), !line_active_reg && last_pixel_reg, "line stayed active after its last pixel")
    // A load restarts the walk at the origin.
    `LRA_ASSERT_NEXT(a_load_restarts, do_load, line_active_reg && (walk_reg.major_offset == '0) && (walk_reg.minor_offset == '0), "load did not restart the walk")
    // The walk never runs past the line's end on either axis.
    `LRA_ASSERT_SAME(a_walk_in_bounds, line_active_reg, (walk_reg.major_offset <= line_cfg_reg.major_length) && (walk_reg.minor_offset <= line_cfg_reg.minor_length), "walk ran past the endpoint")

endmodule

`default_nettype wire

/* rtl/lra_setup.sv */
// ----------------------------------------------------------------------------
// Line setup
// Orders the endpoints by x, folds a falling line onto a rising one and picks
// the major axis.
// ----------------------------------------------------------------------------
`default_nettype none

module lra_setup (
    input  wire lra_pkg::coord_t      start_x,
    input  wire lra_pkg::coord_t      start_y,
    input  wire lra_pkg::coord_t      end_x,
    input  wire lra_pkg::coord_t      end_y,
    output lra_pkg::line_setup_t      setup
);
    import lra_pkg::*;

    logic   swap;
    coord_t ax;
    coord_t ay;
    coord_t bx;
    coord_t by;
    coord_t dx;
    coord_t dy_abs;
    logic   falling;
    logic   steep;

    always_comb
    begin
        // On equal x the first endpoint stays the start point.
        swap    = start_x > end_x;
        ax      = swap ? end_x   : start_x;
        ay      = swap ? end_y   : start_y;
        bx      = swap ? start_x : end_x;
        by      = swap ? start_y : end_y;
        dx      = bx - ax;
        falling = by < ay;
        dy_abs  = falling ? (ay - by) : (by - ay);
        steep   = dy_abs > dx;

        setup.origin_x     = ax;
        setup.origin_y     = ay;
        setup.major_length = steep ? dy_abs : dx;
        setup.minor_length = steep ? dx : dy_abs;
        setup.steep        = steep;
        setup.mirror       = falling;
    end

endmodule

`default_nettype wire

/* rtl/lra_step.sv */
// ----------------------------------------------------------------------------
// Line step
// Maps the current walk position back to screen coordinates and advances the
// error term by one major step.
// ----------------------------------------------------------------------------
`default_nettype none

module lra_step (
    input  wire lra_pkg::line_setup_t line_cfg,
    input  wire lra_pkg::walk_t       walk,
    output lra_pkg::coord_t           pixel_x,
    output lra_pkg::coord_t           pixel_y,
    output logic                      last,
    output lra_pkg::walk_t            walk_next
);
    import lra_pkg::*;

    coord_t xoff;
    coord_t yoff;
    err_t   err_add;
    err_t   two_minor;
    err_t   two_major;

    always_comb
    begin
        xoff    = line_cfg.steep ? walk.minor_offset : walk.major_offset;
        yoff    = line_cfg.steep ? walk.major_offset : walk.minor_offset;
        pixel_x = line_cfg.origin_x + xoff;
        pixel_y = line_cfg.mirror ? (line_cfg.origin_y - yoff)
                                  : (line_cfg.origin_y + yoff);
        last    = walk.major_offset >= line_cfg.major_length;

        two_minor = err_t'({2'b00, line_cfg.minor_length, 1'b0});
        two_major = err_t'({2'b00, line_cfg.major_length, 1'b0});
        err_add   = walk.error_term + two_minor;

        walk_next.major_offset = walk.major_offset + coord_t'(1);
        if (!err_add[ERR_BITS-1])
        begin
            walk_next.minor_offset = walk.minor_offset + coord_t'(1);
            walk_next.error_term   = err_add - two_major;
        end
        else
        begin
            walk_next.minor_offset = walk.minor_offset;
            walk_next.error_term   = err_add;
        end
    end

endmodule

`default_nettype wire
